// ===== rtl/agbk_pkg.sv =====
`default_nettype none
package agbk_pkg;

    // reset values of the noise registers, unsigned q15.16
    localparam logic [30:0] MEAS_NOISE_RST  = 31'd19661;
    localparam logic [30:0] GYRO_NOISE_RST  = 31'd197;
    localparam logic [30:0] ANGLE_NOISE_RST = 31'd66;
    localparam logic [31:0] Q_ONE           = 32'sh0001_0000;

    // register indexes on the config port
    localparam logic [1:0] REG_MEAS_NOISE  = 2'd0;
    localparam logic [1:0] REG_GYRO_NOISE  = 2'd1;
    localparam logic [1:0] REG_ANGLE_NOISE = 2'd2;

    // input kinds
    localparam logic MODE_PREDICT = 1'b0;
    localparam logic MODE_UPDATE  = 1'b1;

    // multiply and write back operations
    localparam logic [3:0] OP_ANG_P  = 4'd0;
    localparam logic [3:0] OP_AA_P   = 4'd1;
    localparam logic [3:0] OP_AB_P   = 4'd2;
    localparam logic [3:0] OP_BA_P   = 4'd3;
    localparam logic [3:0] OP_BB_P   = 4'd4;
    localparam logic [3:0] OP_AA_U   = 4'd5;
    localparam logic [3:0] OP_AB_U   = 4'd6;
    localparam logic [3:0] OP_BA_U   = 4'd7;
    localparam logic [3:0] OP_BB_U   = 4'd8;
    localparam logic [3:0] OP_ANG_U  = 4'd9;
    localparam logic [3:0] OP_BIAS_U = 4'd10;

    localparam int DIV_STEPS = 48;

    typedef struct packed {
        logic       capture;
        logic       rate;
        logic       mul;
        logic       wb;
        logic       div_start;
        logic       div_sel;
        logic       load_out;
        logic [3:0] op;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic div_done;
    } status_t;

endpackage
`default_nettype wire

// ===== rtl/angle_gyro_bias_kalman_top.sv =====
// two-state kalman filter (angle, gyro bias), one request at a time
// predict: rate step, then five multiply/write-back pairs, then the result is loaded
// update: two 48-step restoring gain divides, then multiply/write-back pairs
// a new request is taken only after the last result is loaded, which waits on any output stall
// rst_n asynchronous low: state to angle 0, bias 0, rate 0, P = identity, noise registers to defaults
`default_nettype none
module angle_gyro_bias_kalman_top (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [79:0]  s_tdata,   // gyro_rate[31:0], time_step[47:32], measured_angle[79:48]
    input  wire          s_tuser,   // mode
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [103:0] m_tdata,   // angle_estimate[31:0], rate_estimate[63:32],
                                    // bias_estimate[95:64], saturated[96], zeros above
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [3:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    agbk_pkg::cmd_t    cmd;
    agbk_pkg::status_t status;

    logic [30:0] meas_noise_reg, gyro_noise_reg, angle_noise_reg;
    logic        cfg_wr;

    // config registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meas_noise_reg  <= agbk_pkg::MEAS_NOISE_RST;
            gyro_noise_reg  <= agbk_pkg::GYRO_NOISE_RST;
            angle_noise_reg <= agbk_pkg::ANGLE_NOISE_RST;
        end
        else if (cfg_wr && paddr[1:0] == 2'b00)
        begin
            case (paddr[3:2])
                agbk_pkg::REG_MEAS_NOISE:  meas_noise_reg  <= pwdata[30:0];
                agbk_pkg::REG_GYRO_NOISE:  gyro_noise_reg  <= pwdata[30:0];
                agbk_pkg::REG_ANGLE_NOISE: angle_noise_reg <= pwdata[30:0];
                default:                   meas_noise_reg  <= meas_noise_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (paddr[3:2])
            agbk_pkg::REG_MEAS_NOISE:  prdata = {1'b0, meas_noise_reg};
            agbk_pkg::REG_GYRO_NOISE:  prdata = {1'b0, gyro_noise_reg};
            agbk_pkg::REG_ANGLE_NOISE: prdata = {1'b0, angle_noise_reg};
            default:                   prdata = '0;
        endcase
    end

    agbk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    agbk_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_mode     (s_tuser),
        .in_data     (s_tdata),
        .meas_noise  (meas_noise_reg),
        .gyro_noise  (gyro_noise_reg),
        .angle_noise (angle_noise_reg),
        .out_data    (m_tdata)
    );

    // only one request in flight
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // every write-back follows its multiply
    a_wb_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wb |-> $past(cmd.mul))
        else $error("write-back without product");

    // divider never restarted while a request is being captured
    a_div_capture: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.div_start && cmd.capture))
        else $error("divider start during capture");

    // result loads only when the output side is free
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("result overwritten");

endmodule
`default_nettype wire

// ===== rtl/agbk_div.sv =====
`default_nettype none
module agbk_div (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    input  wire signed [47:0]  num,
    input  wire signed [32:0]  den,
    output logic               done,
    output logic signed [31:0] quo,
    output logic               sat
);

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [47:0] q_reg;
    logic [32:0] rem_reg;
    logic [32:0] den_reg;
    logic        neg_reg;
    logic        zero_reg;
    logic        done_reg;

    logic [33:0] rem_shift;
    logic        fits;
    logic [47:0] num_mag;
    logic [32:0] den_mag;

    // magnitudes of the operands
    assign num_mag = num[47] ? 48'(-num) : 48'(num);
    assign den_mag = den[32] ? 33'(-den) : 33'(den);

    // one restoring step
    assign rem_shift = {rem_reg, q_reg[47]};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(agbk_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operand and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg    <= num_mag;
            rem_reg  <= '0;
            den_reg  <= den_mag;
            neg_reg  <= num[47] ^ den[32];
            zero_reg <= (den == '0);
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[46:0], fits};
            rem_reg <= fits ? 33'(rem_shift - {1'b0, den_reg}) : rem_shift[32:0];
        end
    end

    // sign and clamp of the quotient
    always_comb
    begin
        quo = '0;
        sat = 1'b0;
        if (!zero_reg)
        begin
            if (!neg_reg)
            begin
                if (q_reg > 48'h0000_7FFF_FFFF)
                begin
                    quo = 32'sh7FFF_FFFF;
                    sat = 1'b1;
                end
                else
                    quo = q_reg[31:0];
            end
            else
            begin
                if (q_reg > 48'h0000_8000_0000)
                begin
                    quo = 32'sh8000_0000;
                    sat = 1'b1;
                end
                else
                    quo = 32'(-q_reg);
            end
        end
    end

    assign done = done_reg;

endmodule
`default_nettype wire

// ===== rtl/agbk_dp.sv =====
`default_nettype none
module agbk_dp (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire agbk_pkg::cmd_t   cmd,
    output agbk_pkg::status_t     status,
    input  wire                   in_mode,
    input  wire [79:0]            in_data,
    input  wire [30:0]            meas_noise,
    input  wire [30:0]            gyro_noise,
    input  wire [30:0]            angle_noise,
    output logic [103:0]          out_data
);

    // filter state
    logic signed [31:0] angle_reg, bias_reg, rate_reg;
    logic signed [31:0] aa_reg, ab_reg, ba_reg, bb_reg;
    logic               sat_reg;

    // copies taken when the request is accepted
    logic signed [31:0] angle_s_reg, bias_s_reg;
    logic signed [31:0] aa_s_reg, ab_s_reg, ba_s_reg, bb_s_reg;
    logic signed [31:0] gyro_reg, meas_reg;
    logic [15:0]        dt_reg;
    logic               mode_reg;

    logic signed [31:0] k0_reg, k1_reg;
    logic signed [67:0] prod_reg;
    logic [103:0]       out_reg;

    logic signed [32:0] y_val, s_val, ub_full;
    logic signed [33:0] d_aa, d_off, op_a, op_b;
    logic signed [31:0] base, ub_sat;
    logic               do_sub;
    logic signed [51:0] term;
    logic signed [52:0] sum;
    logic signed [31:0] sum_sat;
    logic               sum_ovf;

    logic               div_done, div_sat;
    logic signed [31:0] div_q;
    logic signed [47:0] div_num;

    assign y_val = 33'(meas_reg) - 33'(angle_s_reg);
    assign s_val = $signed({2'b00, meas_noise}) + 33'(aa_s_reg);
    assign d_aa  = $signed({3'b000, angle_noise}) - 34'(ab_s_reg) - 34'(ba_s_reg);
    assign d_off = -34'(bb_s_reg);

    // unbiased rate with clamp
    assign ub_full = 33'(gyro_reg) - 33'(bias_s_reg);
    always_comb
    begin
        if (ub_full > 33'sh0_7FFF_FFFF)
            ub_sat = 32'sh7FFF_FFFF;
        else if (ub_full < -33'sh0_8000_0000)
            ub_sat = 32'sh8000_0000;
        else
            ub_sat = ub_full[31:0];
    end

    // operand selection per operation
    always_comb
    begin
        op_a   = '0;
        op_b   = '0;
        base   = '0;
        do_sub = 1'b0;
        case (cmd.op)
            agbk_pkg::OP_ANG_P:
            begin
                op_a = 34'(rate_reg);
                op_b = $signed({18'd0, dt_reg});
                base = angle_s_reg;
            end
            agbk_pkg::OP_AA_P:
            begin
                op_a = d_aa;
                op_b = $signed({18'd0, dt_reg});
                base = aa_s_reg;
            end
            agbk_pkg::OP_AB_P:
            begin
                op_a = d_off;
                op_b = $signed({18'd0, dt_reg});
                base = ab_s_reg;
            end
            agbk_pkg::OP_BA_P:
            begin
                op_a = d_off;
                op_b = $signed({18'd0, dt_reg});
                base = ba_s_reg;
            end
            agbk_pkg::OP_BB_P:
            begin
                op_a = $signed({3'b000, gyro_noise});
                op_b = $signed({18'd0, dt_reg});
                base = bb_s_reg;
            end
            agbk_pkg::OP_AA_U:
            begin
                op_a   = 34'(k0_reg);
                op_b   = 34'(aa_s_reg);
                base   = aa_s_reg;
                do_sub = 1'b1;
            end
            agbk_pkg::OP_AB_U:
            begin
                op_a   = 34'(k0_reg);
                op_b   = 34'(ab_s_reg);
                base   = ab_s_reg;
                do_sub = 1'b1;
            end
            agbk_pkg::OP_BA_U:
            begin
                op_a   = 34'(k1_reg);
                op_b   = 34'(aa_s_reg);
                base   = ba_s_reg;
                do_sub = 1'b1;
            end
            agbk_pkg::OP_BB_U:
            begin
                op_a   = 34'(k1_reg);
                op_b   = 34'(ab_s_reg);
                base   = bb_s_reg;
                do_sub = 1'b1;
            end
            agbk_pkg::OP_ANG_U:
            begin
                op_a = 34'(k0_reg);
                op_b = 34'(y_val);
                base = angle_s_reg;
            end
            agbk_pkg::OP_BIAS_U:
            begin
                op_a = 34'(k1_reg);
                op_b = 34'(y_val);
                base = bias_s_reg;
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    // floor shift of the product, add to or subtract from base, clamp
    assign term = 52'(prod_reg >>> 16);
    assign sum  = do_sub ? (53'(base) - 53'(term)) : (53'(base) + 53'(term));
    always_comb
    begin
        sum_ovf = 1'b1;
        if (sum > 53'sh0_0000_7FFF_FFFF)
            sum_sat = 32'sh7FFF_FFFF;
        else if (sum < -53'sh0_0000_8000_0000)
            sum_sat = 32'sh8000_0000;
        else
        begin
            sum_sat = sum[31:0];
            sum_ovf = 1'b0;
        end
    end

    // gain divider
    assign div_num = cmd.div_sel ? {ba_s_reg, 16'd0} : {aa_s_reg, 16'd0};

    agbk_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (s_val),
        .done  (div_done),
        .quo   (div_q),
        .sat   (div_sat)
    );

    // filter state and flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= '0;
            bias_reg  <= '0;
            rate_reg  <= '0;
            aa_reg    <= agbk_pkg::Q_ONE;
            ab_reg    <= '0;
            ba_reg    <= '0;
            bb_reg    <= agbk_pkg::Q_ONE;
            sat_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
                sat_reg <= 1'b0;
            if (cmd.rate)
            begin
                rate_reg <= ub_sat;
                if (ub_full != 33'(ub_sat))
                    sat_reg <= 1'b1;
            end
            if (div_done && div_sat)
                sat_reg <= 1'b1;
            if (cmd.wb)
            begin
                if (sum_ovf)
                    sat_reg <= 1'b1;
                case (cmd.op)
                    agbk_pkg::OP_ANG_P, agbk_pkg::OP_ANG_U: angle_reg <= sum_sat;
                    agbk_pkg::OP_AA_P, agbk_pkg::OP_AA_U:   aa_reg    <= sum_sat;
                    agbk_pkg::OP_AB_P, agbk_pkg::OP_AB_U:   ab_reg    <= sum_sat;
                    agbk_pkg::OP_BA_P, agbk_pkg::OP_BA_U:   ba_reg    <= sum_sat;
                    agbk_pkg::OP_BB_P, agbk_pkg::OP_BB_U:   bb_reg    <= sum_sat;
                    agbk_pkg::OP_BIAS_U:                    bias_reg  <= sum_sat;
                    default:                                bias_reg  <= bias_reg;
                endcase
            end
        end
    end

    // request capture, gains, product and result register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg    <= in_mode;
            gyro_reg    <= in_data[31:0];
            dt_reg      <= in_data[47:32];
            meas_reg    <= in_data[79:48];
            angle_s_reg <= angle_reg;
            bias_s_reg  <= bias_reg;
            aa_s_reg    <= aa_reg;
            ab_s_reg    <= ab_reg;
            ba_s_reg    <= ba_reg;
            bb_s_reg    <= bb_reg;
        end
        if (div_done)
        begin
            if (cmd.div_sel)
                k1_reg <= div_q;
            else
                k0_reg <= div_q;
        end
        if (cmd.mul)
            prod_reg <= op_a * op_b;
        if (cmd.load_out)
            out_reg <= {7'd0, sat_reg, bias_reg, rate_reg, angle_reg};
    end

    assign status.mode     = mode_reg;
    assign status.div_done = div_done;
    assign out_data        = out_reg;

endmodule
`default_nettype wire

// ===== rtl/agbk_ctrl.sv =====
`default_nettype none
module agbk_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire                 out_ready,
    input  wire agbk_pkg::status_t status,
    output agbk_pkg::cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RATE = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_WB   = 3'd3;
    localparam logic [2:0] ST_DIVS = 3'd4;
    localparam logic [2:0] ST_DIVW = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [3:0] op_reg, op_next;
    logic       sel_reg, sel_next;
    logic       valid_reg, valid_next;
    logic       out_free;
    logic [3:0] last_op;

    assign out_free = !valid_reg || out_ready;
    assign last_op  = (status.mode == agbk_pkg::MODE_UPDATE) ? agbk_pkg::OP_BIAS_U
                                                             : agbk_pkg::OP_BB_P;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        sel_next      = sel_reg;
        valid_next    = valid_reg && !out_ready;
        cmd           = '0;
        cmd.op        = op_reg;
        cmd.div_sel   = sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = ST_RATE;
            end
            ST_RATE:
            begin
                if (status.mode == agbk_pkg::MODE_UPDATE)
                begin
                    sel_next   = 1'b0;
                    state_next = ST_DIVS;
                end
                else
                begin
                    cmd.rate   = 1'b1;
                    op_next    = agbk_pkg::OP_ANG_P;
                    state_next = ST_MUL;
                end
            end
            ST_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (status.div_done)
                begin
                    if (!sel_reg)
                    begin
                        sel_next   = 1'b1;
                        state_next = ST_DIVS;
                    end
                    else
                    begin
                        op_next    = agbk_pkg::OP_AA_U;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_WB;
            end
            ST_WB:
            begin
                cmd.wb = 1'b1;
                if (op_reg == last_op)
                    state_next = ST_OUT;
                else
                begin
                    op_next    = op_reg + 4'd1;
                    state_next = ST_MUL;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= agbk_pkg::OP_ANG_P;
            sel_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            sel_reg   <= sel_next;
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = valid_reg;

endmodule
`default_nettype wire
